/* sv/tone_sequencer_command_step_macros.svh */
// Assertion macros shared by the tone sequencer RTL.
`ifndef TONE_SEQUENCER_COMMAND_STEP_MACROS_SVH
`define TONE_SEQUENCER_COMMAND_STEP_MACROS_SVH

// checked outside reset only
`define TSQ_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define TSQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/tsq_pkg.sv */
// Shared constants, types and the tone period table of the tone sequencer.
package tsq_pkg;

	localparam int unsigned DIV_DVD_W = 12;
	localparam int unsigned DIV_DSR_W = 8;
	localparam int unsigned DIV_CNT_W = $clog2(DIV_DVD_W);

	localparam logic [7:0] CMD_NOTE_LIMIT = 8'd12;
	localparam logic [7:0] CMD_OCTAVE     = 8'd12;
	localparam logic [7:0] CMD_TEMPO      = 8'd22;
	localparam logic [7:0] CMD_VOLUME     = 8'd24;
	localparam logic [7:0] CMD_REST       = 8'd25;
	localparam logic [7:0] CMD_LOOP       = 8'd254;

	localparam logic [7:0] STEP_DOWN = 8'd13;
	localparam logic [7:0] STEP_UP   = 8'd14;

	localparam logic [3:0] OCT_MIN = 4'd3;
	localparam logic [3:0] OCT_MAX = 4'd8;

	localparam logic [DIV_DVD_W-1:0] TICK_BASE = 12'd3600;
	localparam logic [7:0]           WAIT_SAT  = 8'hff;
	localparam logic [7:0]           TRIGGER   = 8'h80;
	localparam logic [3:0]           ENV_LOW   = 4'd7;

	localparam logic [1:0] KIND_NOTE   = 2'd0;
	localparam logic [1:0] KIND_REST   = 2'd1;
	localparam logic [1:0] KIND_REWIND = 2'd2;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	function automatic logic [10:0] period_lookup(input logic [6:0] idx);
		logic [10:0] p;
		case (idx)
			7'd0:  p = 11'd44;   7'd1:  p = 11'd156;  7'd2:  p = 11'd262;
			7'd3:  p = 11'd363;  7'd4:  p = 11'd457;  7'd5:  p = 11'd547;
			7'd6:  p = 11'd631;  7'd7:  p = 11'd710;  7'd8:  p = 11'd786;
			7'd9:  p = 11'd854;  7'd10: p = 11'd923;  7'd11: p = 11'd986;
			7'd12: p = 11'd1046; 7'd13: p = 11'd1102; 7'd14: p = 11'd1155;
			7'd15: p = 11'd1205; 7'd16: p = 11'd1253; 7'd17: p = 11'd1297;
			7'd18: p = 11'd1339; 7'd19: p = 11'd1379; 7'd20: p = 11'd1417;
			7'd21: p = 11'd1452; 7'd22: p = 11'd1486; 7'd23: p = 11'd1517;
			7'd24: p = 11'd1546; 7'd25: p = 11'd1575; 7'd26: p = 11'd1602;
			7'd27: p = 11'd1627; 7'd28: p = 11'd1650; 7'd29: p = 11'd1673;
			7'd30: p = 11'd1694; 7'd31: p = 11'd1714; 7'd32: p = 11'd1732;
			7'd33: p = 11'd1750; 7'd34: p = 11'd1767; 7'd35: p = 11'd1783;
			7'd36: p = 11'd1798; 7'd37: p = 11'd1812; 7'd38: p = 11'd1825;
			7'd39: p = 11'd1837; 7'd40: p = 11'd1849; 7'd41: p = 11'd1860;
			7'd42: p = 11'd1871; 7'd43: p = 11'd1881; 7'd44: p = 11'd1890;
			7'd45: p = 11'd1899; 7'd46: p = 11'd1907; 7'd47: p = 11'd1915;
			7'd48: p = 11'd1923; 7'd49: p = 11'd1930; 7'd50: p = 11'd1936;
			7'd51: p = 11'd1943; 7'd52: p = 11'd1949; 7'd53: p = 11'd1954;
			7'd54: p = 11'd1959; 7'd55: p = 11'd1964; 7'd56: p = 11'd1969;
			7'd57: p = 11'd1974; 7'd58: p = 11'd1978; 7'd59: p = 11'd1982;
			7'd60: p = 11'd1985; 7'd61: p = 11'd1988; 7'd62: p = 11'd1992;
			7'd63: p = 11'd1995; 7'd64: p = 11'd1998; 7'd65: p = 11'd2001;
			7'd66: p = 11'd2004; 7'd67: p = 11'd2006; 7'd68: p = 11'd2009;
			7'd69: p = 11'd2011; 7'd70: p = 11'd2013; 7'd71: p = 11'd2015;
			default: p = 11'd2015;
		endcase
		return p;
	endfunction

endpackage

/* sv/tone_sequencer_command_step.sv */
// Tone sequencer command step: command decode, state, period table, wait divider.
// One item at a time. A note or rest with nonzero tempo and length passes from input
// transfer through the bit-serial wait divider and a push state to the output register.
// A tempo command holds input off while 3600/tempo is refreshed.
// Other commands, and zero tempo or length, skip the divider.
// Reset (arst_n low) clears tempo and volume, sets the octave to 3, drops the output.
module tone_sequencer_command_step
	import tsq_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // [7:0] action, [15:8] argument
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // [7:0] envelope_byte, [15:8] period_low,
	                                   // [23:16] control_byte, [31:24] wait_ticks
	output logic [1:0]  m_axis_tuser   // [1:0] kind
);

`include "tone_sequencer_command_step_macros.svh"

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_TEMPO = 4'b0010,
		ST_NOTE  = 4'b0100,
		ST_PUSH  = 4'b1000
	} state_t;

	state_t state_q;

	logic [7:0] tempo_q;
	logic [3:0] volume_q;
	logic [3:0] octave_q;
	logic [DIV_DVD_W-1:0] base_q;

	logic [1:0] kind_q;
	logic [7:0] env_q;
	logic [7:0] lo_q;
	logic [7:0] ctl_q;
	logic [7:0] wait_q;

	logic        out_valid_q;
	logic [1:0]  out_kind_q;
	logic [31:0] out_data_q;

	logic [7:0] action;
	logic [7:0] argument;
	logic       accept;
	logic       is_note;
	logic       is_timed;
	logic       div_start;
	logic       out_free;

	logic [DIV_DVD_W-1:0] div_dvd;
	logic [DIV_DSR_W-1:0] div_dsr;
	logic [DIV_DVD_W-1:0] div_quot;
	div_stat_t            div_stat;

	logic [6:0]  rom_idx;
	logic [10:0] period;
	logic [3:0]  oct_next;
	logic [7:0]  wait_sat;

	assign action        = s_axis_tdata[7:0];
	assign argument      = s_axis_tdata[15:8];
	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign is_note       = action < CMD_NOTE_LIMIT;
	assign is_timed      = is_note || (action == CMD_REST);
	assign out_free      = !out_valid_q || m_axis_tready;

	assign rom_idx = {(octave_q[2:0] - OCT_MIN[2:0]), 3'b000}
	               + {1'b0, (octave_q[2:0] - OCT_MIN[2:0]), 2'b00}
	               + action[6:0];
	assign period  = period_lookup(rom_idx);

	assign wait_sat = (div_quot[DIV_DVD_W-1:8] != '0) ? WAIT_SAT : div_quot[7:0];

	always_comb begin
		div_start = 1'b0;
		div_dvd   = base_q;
		div_dsr   = argument;
		if (accept) begin
			if (action == CMD_TEMPO) begin
				div_dvd   = TICK_BASE;
				div_start = (argument != '0);
			end else if (is_timed) begin
				div_start = (argument != '0) && (tempo_q != '0);
			end
		end
	end

	always_comb begin
		oct_next = octave_q;
		if (argument == STEP_DOWN) begin
			if (octave_q > OCT_MIN)
				oct_next = octave_q - 1'b1;
		end else if (argument == STEP_UP) begin
			if (octave_q < OCT_MAX)
				oct_next = octave_q + 1'b1;
		end else if (argument < {4'd0, OCT_MIN}) begin
			oct_next = OCT_MIN;
		end else if (argument > {4'd0, OCT_MAX}) begin
			oct_next = OCT_MAX;
		end else begin
			oct_next = argument[3:0];
		end
	end

	tsq_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dsr),
		.stat     (div_stat),
		.quotient (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			tempo_q  <= '0;
			volume_q <= '0;
			octave_q <= OCT_MIN;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (action == CMD_OCTAVE) begin
							octave_q <= oct_next;
						end else if (action == CMD_TEMPO) begin
							tempo_q <= argument;
							if (div_start)
								state_q <= ST_TEMPO;
						end else if (action == CMD_VOLUME) begin
							volume_q <= argument[3:0];
						end else if (is_timed) begin
							state_q <= div_start ? ST_NOTE : ST_PUSH;
						end else if (action == CMD_LOOP) begin
							state_q <= ST_PUSH;
						end
					end
				end
				ST_TEMPO: begin
					if (div_stat.done)
						state_q <= ST_IDLE;
				end
				ST_NOTE: begin
					if (div_stat.done)
						state_q <= ST_PUSH;
				end
				ST_PUSH: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_TEMPO && div_stat.done)
			base_q <= div_quot;
		if (accept) begin
			if (is_note) begin
				kind_q <= KIND_NOTE;
				env_q  <= {volume_q, ENV_LOW};
				lo_q   <= period[7:0];
				ctl_q  <= TRIGGER | {5'd0, period[10:8]};
				wait_q <= WAIT_SAT;
			end else if (action == CMD_REST) begin
				kind_q <= KIND_REST;
				env_q  <= '0;
				lo_q   <= '0;
				ctl_q  <= '0;
				wait_q <= WAIT_SAT;
			end else begin
				kind_q <= KIND_REWIND;
				env_q  <= '0;
				lo_q   <= '0;
				ctl_q  <= '0;
				wait_q <= '0;
			end
		end else if (state_q == ST_NOTE && div_stat.done) begin
			wait_q <= wait_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_PUSH && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_PUSH && out_free) begin
			out_kind_q <= kind_q;
			out_data_q <= {wait_q, ctl_q, lo_q, env_q};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_kind_q;

	`TSQ_ASSERT(a_octave_range, clk, arst_n, (octave_q >= OCT_MIN) && (octave_q <= OCT_MAX), "octave left 3..8")
	`TSQ_ASSERT(a_div_owner, clk, arst_n, div_stat.busy |-> (state_q == ST_TEMPO || state_q == ST_NOTE), "divider busy outside a divide state")
	`TSQ_ASSERT(a_note_trigger, clk, arst_n, (m_axis_tvalid && m_axis_tuser == KIND_NOTE) |-> m_axis_tdata[23], "note result without trigger bit")
	`TSQ_ASSERT(a_push_loads, clk, arst_n, (state_q == ST_PUSH && out_free) |=> m_axis_tvalid, "result not presented after push")

endmodule

/* sv/tsq_div.sv */
// Bit-serial restoring divider, one quotient bit per cycle.
module tsq_div
	import tsq_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [DIV_DVD_W-1:0] dividend,
	input  logic [DIV_DSR_W-1:0] divisor,
	output div_stat_t            stat,
	output logic [DIV_DVD_W-1:0] quotient
);

	localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(DIV_DVD_W - 1);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_DVD_W-1:0] dvd_q;
	logic [DIV_DSR_W-1:0] dsr_q;
	logic [DIV_DSR_W-1:0] rem_q;
	logic [DIV_DSR_W:0]   rem_sh;
	logic [DIV_DSR_W:0]   rem_sub;
	logic                 q_bit;

	assign rem_sh  = {rem_q, dvd_q[DIV_DVD_W-1]};
	assign q_bit   = rem_sh >= {1'b0, dsr_q};
	assign rem_sub = rem_sh - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= LAST_STEP;
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DIV_DVD_W-2:0], q_bit};
			rem_q <= q_bit ? rem_sub[DIV_DSR_W-1:0] : rem_sh[DIV_DSR_W-1:0];
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = dvd_q;

endmodule

/* tb/tb_tone_sequencer_command_step.sv */
// Testbench for tone_sequencer_command_step: directed and random stream traffic checked against a predictor.
module tb_tone_sequencer_command_step;
	import tsq_pkg::*;

	localparam int unsigned CYCLE_LIMIT     = 400000;
	localparam int unsigned RANDOM_COMMANDS = 825;
	localparam int unsigned SETTLE_CYCLES   = 40;

	localparam logic [10:0] TONE_PERIOD [72] = '{
		11'd44,   11'd156,  11'd262,  11'd363,  11'd457,  11'd547,
		11'd631,  11'd710,  11'd786,  11'd854,  11'd923,  11'd986,
		11'd1046, 11'd1102, 11'd1155, 11'd1205, 11'd1253, 11'd1297,
		11'd1339, 11'd1379, 11'd1417, 11'd1452, 11'd1486, 11'd1517,
		11'd1546, 11'd1575, 11'd1602, 11'd1627, 11'd1650, 11'd1673,
		11'd1694, 11'd1714, 11'd1732, 11'd1750, 11'd1767, 11'd1783,
		11'd1798, 11'd1812, 11'd1825, 11'd1837, 11'd1849, 11'd1860,
		11'd1871, 11'd1881, 11'd1890, 11'd1899, 11'd1907, 11'd1915,
		11'd1923, 11'd1930, 11'd1936, 11'd1943, 11'd1949, 11'd1954,
		11'd1959, 11'd1964, 11'd1969, 11'd1974, 11'd1978, 11'd1982,
		11'd1985, 11'd1988, 11'd1992, 11'd1995, 11'd1998, 11'd2001,
		11'd2004, 11'd2006, 11'd2009, 11'd2011, 11'd2013, 11'd2015
	};

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] envelope_byte;
		logic [7:0] period_low;
		logic [7:0] control_byte;
		logic [7:0] wait_ticks;
	} tone_result_t;

	class tone_result_predictor;
		logic [7:0]   tempo;
		logic [3:0]   volume;
		logic [3:0]   octave;
		tone_result_t due_results[$];
		int unsigned  mismatch_count;

		function new();
			tempo = '0;
			volume = '0;
			octave = OCT_MIN;
			mismatch_count = 0;
		endfunction

		function logic [7:0] wait_for(logic [7:0] len);
			int unsigned q;
			if (tempo == 0 || len == 0) begin
				return WAIT_SAT;
			end
			q = (int'(TICK_BASE) / int'(tempo)) / int'(len);
			return (q > 255) ? WAIT_SAT : q[7:0];
		endfunction

		function void take_command(logic [7:0] act, logic [7:0] arg);
			tone_result_t r;
			logic [6:0]   idx;
			logic [10:0]  per;
			r = '0;
			if (act < CMD_NOTE_LIMIT) begin
				idx = 7'((int'(octave) - int'(OCT_MIN)) * 12 + int'(act));
				per = TONE_PERIOD[idx];
				r.kind = KIND_NOTE;
				r.envelope_byte = {volume, ENV_LOW};
				r.period_low = per[7:0];
				r.control_byte = TRIGGER | {5'd0, per[10:8]};
				r.wait_ticks = wait_for(arg);
				due_results.push_back(r);
			end else begin
				case (act)
					CMD_OCTAVE: begin
						if (arg == STEP_DOWN) begin
							if (octave > OCT_MIN) octave = octave - 4'd1;
						end else if (arg == STEP_UP) begin
							if (octave < OCT_MAX) octave = octave + 4'd1;
						end else if (arg < OCT_MIN) begin
							octave = OCT_MIN;
						end else if (arg > OCT_MAX) begin
							octave = OCT_MAX;
						end else begin
							octave = arg[3:0];
						end
					end
					CMD_TEMPO: tempo = arg;
					CMD_VOLUME: volume = arg[3:0];
					CMD_REST: begin
						r.kind = KIND_REST;
						r.wait_ticks = wait_for(arg);
						due_results.push_back(r);
					end
					CMD_LOOP: begin
						r.kind = KIND_REWIND;
						due_results.push_back(r);
					end
					default: ;
				endcase
			end
		endfunction

		function void compare_field(string what, logic [7:0] want, logic [7:0] got);
			if (want !== got) begin
				$display("%0t: %s expected %0d actual %0d", $time, what, want, got);
				mismatch_count++;
			end
		endfunction

		function void check_output(logic [1:0] kind, logic [31:0] data);
			tone_result_t want;
			if (due_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual kind %0d data %h",
					$time, kind, data);
				mismatch_count++;
				return;
			end
			want = due_results.pop_front();
			compare_field("kind", {6'd0, want.kind}, {6'd0, kind});
			compare_field("envelope_byte", want.envelope_byte, data[7:0]);
			compare_field("period_low", want.period_low, data[15:8]);
			compare_field("control_byte", want.control_byte, data[23:16]);
			compare_field("wait_ticks", want.wait_ticks, data[31:24]);
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata;   // [7:0] action, [15:8] argument
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;   // [7:0] envelope_byte, [15:8] period_low,
	                             // [23:16] control_byte, [31:24] wait_ticks
	logic [1:0]  m_axis_tuser;   // [1:0] kind

	tone_result_predictor predictor;
	int unsigned          cycle_count = 0;
	bit                   send_calm = 0;

	tone_sequencer_command_step u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tone_sequencer_command_step test failed");
			$finish;
		end
	end

	task automatic send_command(input logic [7:0] act, input logic [7:0] arg);
		int unsigned gap;
		gap = send_calm ? 0 : $urandom_range(0, 15);
		if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {arg, act};
		do @(posedge clk); while (!s_axis_tready);
		predictor.take_command(act, arg);
	endtask

	// hold the input off until every predicted result has been taken
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (predictor.due_results.size() != 0) @(posedge clk);
	endtask

	function automatic logic [7:0] random_length();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0) return 8'd0;
		if (r <= 6) return 8'($urandom_range(1, 16));
		return 8'($urandom_range(0, 255));
	endfunction

	// result sink with random backpressure
	initial begin
		int unsigned stall;
		bit          calm;
		calm = 0;
		m_axis_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 15);
			if ($urandom_range(0, 39) == 0) calm = !calm;
			if (stall != 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			predictor.check_output(m_axis_tuser, m_axis_tdata);
		end
	end

	initial begin
		int unsigned sent;
		int unsigned pick;
		int unsigned r;
		bit          paused;
		logic [7:0]  act;
		logic [7:0]  arg;

		predictor = new();
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reset state, clamps, saturation, every command
		send_command(8'd0, 8'd5);          // zero tempo
		send_command(CMD_REST, 8'd0);
		send_command(CMD_LOOP, 8'd0);
		send_command(CMD_VOLUME, 8'hff);   // only low nibble kept
		send_command(CMD_TEMPO, 8'd1);
		send_command(8'd11, 8'd1);         // wait above 255
		send_command(CMD_OCTAVE, 8'd0);    // clamp up to min
		send_command(CMD_OCTAVE, STEP_DOWN);
		send_command(8'd0, 8'd255);
		send_command(CMD_OCTAVE, 8'd255);  // clamp down to max
		send_command(CMD_OCTAVE, STEP_UP);
		send_command(8'd11, 8'd255);       // last table entry
		send_command(CMD_TEMPO, 8'd255);
		send_command(8'd0, 8'd0);          // zero length
		send_command(CMD_REST, 8'd1);
		send_command(CMD_OCTAVE, STEP_DOWN);
		send_command(8'd23, 8'd77);        // unknown
		send_command(8'd255, 8'd255);      // unknown
		send_command(CMD_VOLUME, 8'h5a);
		send_command(8'd6, 8'd3);
		send_command(CMD_TEMPO, 8'd0);
		send_command(CMD_REST, 8'd200);
		send_command(CMD_OCTAVE, 8'd5);
		send_command(CMD_TEMPO, 8'd14);
		send_command(8'd5, 8'd1);
		drain_results();

		sent = 0;
		paused = 0;
		while (sent < RANDOM_COMMANDS) begin
			pick = $urandom_range(0, 99);
			arg = 8'($urandom_range(0, 255));
			if (pick < 40) begin
				act = 8'($urandom_range(0, 11));
				arg = random_length();
			end else if (pick < 50) begin
				act = CMD_REST;
				arg = random_length();
			end else if (pick < 62) begin
				act = CMD_OCTAVE;
				r = $urandom_range(0, 9);
				if (r < 4) arg = r[0] ? STEP_UP : STEP_DOWN;
				else if (r < 8) arg = 8'($urandom_range(0, 10));
			end else if (pick < 72) begin
				act = CMD_TEMPO;
				r = $urandom_range(0, 9);
				if (r == 0) arg = 8'd0;
				else if (r < 6) arg = 8'($urandom_range(1, 40));
			end else if (pick < 80) begin
				act = CMD_VOLUME;
			end else if (pick < 85) begin
				act = CMD_LOOP;
			end else begin
				do act = 8'($urandom_range(0, 255));
				while (act < CMD_NOTE_LIMIT || act == CMD_OCTAVE || act == CMD_TEMPO ||
					act == CMD_VOLUME || act == CMD_REST || act == CMD_LOOP);
			end
			sent++;
			send_command(act, arg);
			if (!paused && sent == RANDOM_COMMANDS / 2) begin
				paused = 1;
				drain_results();
			end
		end

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (predictor.mismatch_count == 0) begin
			$display("tone_sequencer_command_step test passed");
		end else begin
			$display("tone_sequencer_command_step test failed");
		end
		$finish;
	end

endmodule
